>>> rtl/core/pip_pkg.sv
// Shared types, constants and helpers for the point-in-polygon crossing test.
// Used by point_in_polygon_crossing_test; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

   // Coordinate and vertex word layout: {axis 0, axis 1, axis 2}
   localparam int COORD_W = 32;
   localparam int VTX_W   = 3 * COORD_W;
   localparam int VTX_A_LSB = 2 * COORD_W;
   localparam int VTX_B_LSB = COORD_W;
   localparam int VTX_C_LSB = 0;

   // Default table depth
   localparam int MAX_VERTICES_DEF = 16;

   // Word and register field widths
   localparam int IDX_W    = 4;
   localparam int COUNT_W  = 5;
   localparam int AXIS_W   = 2;
   localparam int TOL_W    = 32;
   localparam int CSR_IDX_W = 2;

   // Product and difference widths
   localparam int DIFF_W = COORD_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int CROSS_W = PROD_W + 1;

   // Request type codes
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_TEST = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DROP_AXIS       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EQUAL_TOLERANCE = 2'd2;

   // Reset values
   localparam logic [COUNT_W-1:0] VERTEX_COUNT_RST = 5'd3;

   // Dropped axis codes; the unused code acts as axis 0
   localparam logic [AXIS_W-1:0] DROP_A = 2'd0;
   localparam logic [AXIS_W-1:0] DROP_B = 2'd1;
   localparam logic [AXIS_W-1:0] DROP_C = 2'd2;

   // Control that travels with each edge through the pipeline
   typedef struct packed {
      logic valid;    // slot holds work
      logic edge_en;  // slot carries a real edge (count of zero sends none)
      logic last;     // final slot of its test
   } pip_tag_type;

   // Projected x: the axis after the dropped one
   function automatic logic [COORD_W-1:0] proj_x(input logic [AXIS_W-1:0] axis,
                                                 input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b,
                                                 input logic [COORD_W-1:0] c);
      logic [COORD_W-1:0] r;
      case (axis)
         DROP_B:  r = c;
         DROP_C:  r = a;
         default: r = b;
      endcase
      return r;
   endfunction

   // Projected y: two axes after the dropped one
   function automatic logic [COORD_W-1:0] proj_y(input logic [AXIS_W-1:0] axis,
                                                 input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b,
                                                 input logic [COORD_W-1:0] c);
      logic [COORD_W-1:0] r;
      case (axis)
         DROP_B:  r = a;
         DROP_C:  r = b;
         default: r = c;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/point_in_polygon_crossing_test.sv
// Point-in-polygon crossing test: vertex table, edge sequencer and edge pipeline.
// Depends on pip_pkg.
//
// Usage:
//  - Request channel (req_*): a word with req_type load writes one vertex into
//    slot req_vertex_index (slots at or above MAX_VERTICES are ignored) and
//    gives no response. A word with req_type test checks the point against the
//    polygon formed by the first vertex_count slots (capped at MAX_VERTICES).
//  - Response channel (rsp_*): one word per test: inside_res and boundary_hit.
//  - Config (csr_*): vertex_count, drop_axis, equal_tolerance; write only while
//    the block is idle.
//  - Throughput: a test holds the edge sequencer until it has issued its last edge
//    (one empty slot for a count of zero); one edge, both ends through two read
//    ports, is read from the vertex table each cycle unless the response is stalled.
//    A load does not hold the sequencer. A new word is taken in the cycle a test issues its last edge.
//  - The response is registered behind the edge pipeline stages (table read,
//    project/subtract, multiply, cross difference, decide).
//  - Reset clears control state and returns config to its reset values; the
//    vertex table is not cleared and holds garbage until loaded.
//  - A stalled response freezes the whole edge pipeline and the request side;
//    nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_crossing_test #(
   parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_type,
   input  wire logic [pip_pkg::IDX_W-1:0]        req_vertex_index,
   input  wire logic [pip_pkg::COORD_W-1:0]      req_coord_a,
   input  wire logic [pip_pkg::COORD_W-1:0]      req_coord_b,
   input  wire logic [pip_pkg::COORD_W-1:0]      req_coord_c,
   // response channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_inside_res,
   output logic                                  rsp_boundary_hit,
   // config write port
   input  wire logic                             csr_we,
   input  wire logic [pip_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [pip_pkg::TOL_W-1:0]        csr_wdata
);

   import pip_pkg::*;

   localparam int IW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);

   // ---------------------------------------------------------------- config
   logic [COUNT_W-1:0] vertex_count_ff;
   logic [AXIS_W-1:0]  drop_axis_ff;
   logic [TOL_W-1:0]   tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VERTEX_COUNT_RST;
         drop_axis_ff    <= DROP_A;
         tol_ff          <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VERTEX_COUNT:    vertex_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_DROP_AXIS:       drop_axis_ff    <= csr_wdata[AXIS_W-1:0];
            CSR_EQUAL_TOLERANCE: tol_ff          <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- handshake
   logic advance;      // whole edge pipeline moves
   logic req_acc;
   logic test_acc;
   logic load_acc;

   logic              busy_ff, busy_in;
   logic [CW-1:0]     left_ff, left_in;
   logic [IW-1:0]     i0_ff, i0_in;
   logic [IW-1:0]     i1_ff, i1_in;
   logic [COORD_W-1:0] px_ff, px_in;
   logic [COORD_W-1:0] py_ff, py_in;
   logic              seq_last;

   logic rsp_valid_ff, rsp_valid_in;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign seq_last  = busy_ff && (left_ff <= CW'(1));
   assign req_stall = !(advance && (!busy_ff || seq_last));
   assign req_acc   = req_valid && !req_stall;
   assign test_acc  = req_acc && (req_type == REQ_TEST);
   assign load_acc  = req_acc && (req_type == REQ_LOAD);

   // ---------------------------------------------------------------- sequencer
   logic [31:0] vc_ext;
   logic [31:0] n_ext;
   logic [31:0] n_m1;

   always_comb begin
      vc_ext = {{(32 - COUNT_W){1'b0}}, vertex_count_ff};
      n_ext  = (vc_ext > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES) : vc_ext;
      n_m1   = n_ext - 32'd1;

      busy_in = busy_ff;
      left_in = left_ff;
      i0_in   = i0_ff;
      i1_in   = i1_ff;
      px_in   = px_ff;
      py_in   = py_ff;

      // step to the next edge
      if (advance && busy_ff) begin
         if (seq_last) begin
            busy_in = 1'b0;
         end else begin
            left_in = left_ff - CW'(1);
            i0_in   = i1_ff;
            i1_in   = i1_ff + IW'(1);
         end
      end

      // new test: closing edge first (last vertex to first)
      if (test_acc) begin
         busy_in = 1'b1;
         left_in = n_ext[CW-1:0];
         i0_in   = (n_ext == 32'd0) ? '0 : n_m1[IW-1:0];
         i1_in   = '0;
         px_in   = proj_x(drop_axis_ff, req_coord_a, req_coord_b, req_coord_c);
         py_in   = proj_y(drop_axis_ff, req_coord_a, req_coord_b, req_coord_c);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
      i0_ff   <= i0_in;
      i1_ff   <= i1_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
   end

   // ---------------------------------------------------------------- vertex table
   logic [VTX_W-1:0] vertex_mem [MAX_VERTICES];
   logic [31:0]      widx_ext;
   logic             mem_we;
   logic [IW-1:0]    wr_addr;

   assign widx_ext = {{(32 - IDX_W){1'b0}}, req_vertex_index};
   assign mem_we   = load_acc && (widx_ext < 32'(MAX_VERTICES));
   assign wr_addr  = widx_ext[IW-1:0];

   // stage A: table read of both edge ends
   logic [VTX_W-1:0]   rd0_a_ff, rd1_a_ff;
   logic [COORD_W-1:0] px_a_ff, py_a_ff;
   pip_tag_type        tag_a_ff, tag_a_in;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         vertex_mem[wr_addr] <= {req_coord_a, req_coord_b, req_coord_c};
      end
      if (advance) begin
         rd0_a_ff <= vertex_mem[i0_ff];
         rd1_a_ff <= vertex_mem[i1_ff];
         px_a_ff  <= px_ff;
         py_a_ff  <= py_ff;
      end
   end

   always_comb begin
      tag_a_in.valid   = busy_ff;
      tag_a_in.edge_en = (left_ff != '0);
      tag_a_in.last    = (left_ff <= CW'(1));
   end

   // ---------------------------------------------------------------- stage B: project, subtract
   logic [COORD_W-1:0]       p0x, p0y, p1x, p1y;
   logic signed [DIFF_W-1:0] dx0_b_in, dy0_b_in, dx1_b_in, dy1_b_in;
   logic signed [DIFF_W-1:0] dx0_b_ff, dy0_b_ff, dx1_b_ff, dy1_b_ff;
   logic                     yup_b_in, yup_b_ff;
   pip_tag_type              tag_b_ff;

   always_comb begin
      p0x = proj_x(drop_axis_ff, rd0_a_ff[VTX_A_LSB +: COORD_W],
                   rd0_a_ff[VTX_B_LSB +: COORD_W], rd0_a_ff[VTX_C_LSB +: COORD_W]);
      p0y = proj_y(drop_axis_ff, rd0_a_ff[VTX_A_LSB +: COORD_W],
                   rd0_a_ff[VTX_B_LSB +: COORD_W], rd0_a_ff[VTX_C_LSB +: COORD_W]);
      p1x = proj_x(drop_axis_ff, rd1_a_ff[VTX_A_LSB +: COORD_W],
                   rd1_a_ff[VTX_B_LSB +: COORD_W], rd1_a_ff[VTX_C_LSB +: COORD_W]);
      p1y = proj_y(drop_axis_ff, rd1_a_ff[VTX_A_LSB +: COORD_W],
                   rd1_a_ff[VTX_B_LSB +: COORD_W], rd1_a_ff[VTX_C_LSB +: COORD_W]);
      dx0_b_in = $signed({p0x[COORD_W-1], p0x} - {px_a_ff[COORD_W-1], px_a_ff});
      dy0_b_in = $signed({p0y[COORD_W-1], p0y} - {py_a_ff[COORD_W-1], py_a_ff});
      dx1_b_in = $signed({p1x[COORD_W-1], p1x} - {px_a_ff[COORD_W-1], px_a_ff});
      dy1_b_in = $signed({p1y[COORD_W-1], p1y} - {py_a_ff[COORD_W-1], py_a_ff});
      yup_b_in = $signed(p1y) > $signed(p0y);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx0_b_ff <= dx0_b_in;
         dy0_b_ff <= dy0_b_in;
         dx1_b_ff <= dx1_b_in;
         dy1_b_ff <= dy1_b_in;
         yup_b_ff <= yup_b_in;
      end
   end

   // ---------------------------------------------------------------- stage C: multiply, side flags
   logic signed [PROD_W-1:0] pa_c_in, pb_c_in, pa_c_ff, pb_c_ff;
   logic [DIFF_W-1:0]        mx0, mx1, my0, my1;
   logic [DIFF_W-1:0]        tol_d;
   logic                     y0_c_in, y1_c_in, x0_c_in, x1_c_in;
   logic                     nx0_c_in, nx1_c_in, ny0_c_in, ny1_c_in;
   logic                     y0_c_ff, y1_c_ff, x0_c_ff, x1_c_ff;
   logic                     nx0_c_ff, nx1_c_ff, ny0_c_ff, ny1_c_ff;
   logic                     yup_c_ff;
   pip_tag_type              tag_c_ff;

   always_comb begin
      pa_c_in = dy0_b_ff * dx1_b_ff;
      pb_c_in = dx0_b_ff * dy1_b_ff;

      // strictly greater: difference positive
      y0_c_in = !dy0_b_ff[DIFF_W-1] && (dy0_b_ff != '0);
      y1_c_in = !dy1_b_ff[DIFF_W-1] && (dy1_b_ff != '0);
      x0_c_in = !dx0_b_ff[DIFF_W-1] && (dx0_b_ff != '0);
      x1_c_in = !dx1_b_ff[DIFF_W-1] && (dx1_b_ff != '0);

      // near-equality on magnitudes
      mx0 = dx0_b_ff[DIFF_W-1] ? DIFF_W'(-dx0_b_ff) : DIFF_W'(dx0_b_ff);
      mx1 = dx1_b_ff[DIFF_W-1] ? DIFF_W'(-dx1_b_ff) : DIFF_W'(dx1_b_ff);
      my0 = dy0_b_ff[DIFF_W-1] ? DIFF_W'(-dy0_b_ff) : DIFF_W'(dy0_b_ff);
      my1 = dy1_b_ff[DIFF_W-1] ? DIFF_W'(-dy1_b_ff) : DIFF_W'(dy1_b_ff);
      tol_d = {{(DIFF_W - TOL_W){1'b0}}, tol_ff};
      nx0_c_in = mx0 <= tol_d;
      nx1_c_in = mx1 <= tol_d;
      ny0_c_in = my0 <= tol_d;
      ny1_c_in = my1 <= tol_d;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pa_c_ff  <= pa_c_in;
         pb_c_ff  <= pb_c_in;
         y0_c_ff  <= y0_c_in;
         y1_c_ff  <= y1_c_in;
         x0_c_ff  <= x0_c_in;
         x1_c_ff  <= x1_c_in;
         nx0_c_ff <= nx0_c_in;
         nx1_c_ff <= nx1_c_in;
         ny0_c_ff <= ny0_c_in;
         ny1_c_ff <= ny1_c_in;
         yup_c_ff <= yup_b_ff;
      end
   end

   // ---------------------------------------------------------------- stage D: cross difference, edge class
   logic [CROSS_W-1:0] d_d_in, d_d_ff;
   logic               straddle;
   logic               full_d_in, slant_d_in, hit_d_in;
   logic               full_d_ff, slant_d_ff, hit_d_ff, yup_d_ff;
   pip_tag_type        tag_d_ff;

   always_comb begin
      d_d_in   = {pa_c_ff[PROD_W-1], pa_c_ff} - {pb_c_ff[PROD_W-1], pb_c_ff};
      straddle = y0_c_ff != y1_c_ff;
      // both ends right of the point: plain crossing
      full_d_in  = straddle && x0_c_ff && x1_c_ff;
      // one end right: decided by the cross product
      slant_d_in = straddle && (x0_c_ff != x1_c_ff);
      // vertical edge through the point, or horizontal edge through it
      hit_d_in   = (straddle && !x0_c_ff && !x1_c_ff && nx0_c_ff && nx1_c_ff)
                || (!straddle && ny0_c_ff && ny1_c_ff && (x0_c_ff != x1_c_ff));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_d_ff     <= d_d_in;
         full_d_ff  <= full_d_in;
         slant_d_ff <= slant_d_in;
         hit_d_ff   <= hit_d_in;
         yup_d_ff   <= yup_c_ff;
      end
   end

   // ---------------------------------------------------------------- stage E: per-edge verdict
   logic               d_neg;
   logic [CROSS_W-1:0] d_mag;
   logic               d_small;
   logic               a_gt_b;
   logic               hit_e_in, cross_e_in, hit_e_ff, cross_e_ff;
   pip_tag_type        tag_e_ff;

   always_comb begin
      d_neg   = d_d_ff[CROSS_W-1];
      d_mag   = d_neg ? (~d_d_ff + CROSS_W'(1)) : d_d_ff;
      d_small = d_mag <= {{(CROSS_W - TOL_W){1'b0}}, tol_ff};
      a_gt_b  = !d_neg && (d_d_ff != '0);
      hit_e_in   = tag_d_ff.edge_en && (hit_d_ff || (slant_d_ff && d_small));
      cross_e_in = tag_d_ff.edge_en
                && (full_d_ff || (slant_d_ff && (yup_d_ff != a_gt_b)));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hit_e_ff   <= hit_e_in;
         cross_e_ff <= cross_e_in;
      end
   end

   // ---------------------------------------------------------------- valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff <= '0;
         tag_b_ff <= '0;
         tag_c_ff <= '0;
         tag_d_ff <= '0;
         tag_e_ff <= '0;
      end else if (advance) begin
         tag_a_ff <= tag_a_in;
         tag_b_ff <= tag_a_ff;
         tag_c_ff <= tag_b_ff;
         tag_d_ff <= tag_c_ff;
         tag_e_ff <= tag_d_ff;
      end
   end

   // ---------------------------------------------------------------- accumulate, response word
   logic acc_hit_ff, acc_hit_in;
   logic acc_par_ff, acc_par_in;
   logic hit_all, par_all;
   logic done;
   logic rsp_inside_ff, rsp_inside_in;
   logic rsp_hit_ff, rsp_hit_in;

   always_comb begin
      hit_all = acc_hit_ff || hit_e_ff;
      par_all = acc_par_ff ^ cross_e_ff;
      done    = advance && tag_e_ff.valid && tag_e_ff.last;

      acc_hit_in    = acc_hit_ff;
      acc_par_in    = acc_par_ff;
      rsp_inside_in = rsp_inside_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (advance && tag_e_ff.valid) begin
         if (tag_e_ff.last) begin
            acc_hit_in = 1'b0;
            acc_par_in = 1'b0;
         end else begin
            acc_hit_in = hit_all;
            acc_par_in = par_all;
         end
      end

      // a boundary hit wins over the crossing parity
      if (done) begin
         rsp_valid_in  = 1'b1;
         rsp_inside_in = hit_all || par_all;
         rsp_hit_in    = hit_all;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_hit_ff   <= 1'b0;
         acc_par_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_hit_ff   <= acc_hit_in;
         acc_par_ff   <= acc_par_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_inside_ff <= rsp_inside_in;
      rsp_hit_ff    <= rsp_hit_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_inside_res   = rsp_inside_ff;
   assign rsp_boundary_hit = rsp_hit_ff;

   // ---------------------------------------------------------------- assertions
`ifndef SYNTHESIS
   a_hit_is_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_ff |-> rsp_inside_ff)
      else $error("boundary hit reported as outside");

   a_no_take_mid_walk: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !seq_last |-> req_stall)
      else $error("request taken while edges remain to issue");

   a_test_starts_walk: assert property (@(posedge clock) disable iff (reset)
      test_acc |=> busy_ff)
      else $error("accepted test did not start the edge walk");

   a_stall_freezes_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(tag_e_ff) && $stable(acc_par_ff))
      else $error("edge pipeline moved under a stalled response");
`endif

endmodule

`default_nettype wire
